/* rtl/spms_pkg.sv */
// Package for the shared-pool multi-stack unit: sizes, payload structs and status codes.
// It has no dependencies. Every module of the block uses it by scoped names.
package spms_pkg;

  localparam int STACKS   = 8;
  localparam int CAPACITY = 64;
  localparam int QDEPTH   = 2;

  localparam int STK_W  = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  typedef logic [STK_W-1:0]  stk_idx_t;
  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [6:0]        total_t;
  typedef logic [15:0]       serial_t;

  localparam logic       REQ_PUSH = 1'b0;
  localparam logic       REQ_POP  = 1'b1;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_UNF = 2'd2;

  localparam total_t CAP_LIMIT_RST = 7'd64;

  typedef struct packed {
    logic       req_type;
    logic [3:0] stack_select;
  } spms_req_t;

  typedef struct packed {
    logic [1:0] status;
    serial_t    item_serial;
    total_t     total_count;
  } spms_rsp_t;

  typedef struct packed {
    logic     is_pop;
    logic     sel_ok;
    stk_idx_t stack;
  } spms_op_t;

  typedef struct packed {
    logic fin;
    cnt_t pool_count;
    cnt_t free_top;
  } spms_mon_t;

endpackage

/* rtl/spms_front.sv */
// Front end of the shared-pool multi-stack unit: decodes requests and queues them.
// Depends on spms_pkg for the request and decoded-operation types.
module spms_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spms_pkg::spms_req_t in_data_i,
  output logic                deq_valid_o,
  input  logic                deq_ready_i,
  output spms_pkg::spms_op_t  deq_op_o
);

  spms_pkg::spms_op_t op_in;
  spms_pkg::spms_op_t queue_q [spms_pkg::QDEPTH];
  logic [$clog2(spms_pkg::QDEPTH)-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [$clog2(spms_pkg::QDEPTH+1)-1:0] count_q, count_d;
  logic enq, deq;

  always_comb begin
    op_in.is_pop = (in_data_i.req_type == spms_pkg::REQ_POP);
    op_in.sel_ok = (in_data_i.stack_select >= 4'd1) &&
                   (32'(in_data_i.stack_select) <= 32'(spms_pkg::STACKS));
    op_in.stack  = spms_pkg::stk_idx_t'(in_data_i.stack_select - 4'd1);
  end

  assign in_ready_o  = (32'(count_q) != 32'(spms_pkg::QDEPTH));
  assign deq_valid_o = (count_q != '0);
  assign deq_op_o    = queue_q[rd_ptr_q];
  assign enq         = in_valid_i && in_ready_o;
  assign deq         = deq_valid_o && deq_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (enq) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (deq) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (enq && !deq) begin
      count_d = count_q + 1'b1;
    end else if (deq && !enq) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      queue_q[wr_ptr_q] <= op_in;
    end
  end

endmodule

/* rtl/spms_back.sv */
// Back end of the shared-pool multi-stack unit: executes queued operations against
// the slot, link and free-list memories and holds the result register. Uses spms_pkg.
module spms_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [6:0]          cfg_data_i,
  input  logic                deq_valid_i,
  output logic                deq_ready_o,
  input  spms_pkg::spms_op_t  deq_op_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output spms_pkg::spms_rsp_t out_data_o,
  output spms_pkg::spms_mon_t mon_o
);

  localparam logic S_ISSUE = 1'b0;
  localparam logic S_FIN   = 1'b1;

  logic state_q, state_d;

  spms_pkg::serial_t   ser_mem  [spms_pkg::CAPACITY];
  spms_pkg::slot_idx_t link_mem [spms_pkg::CAPACITY];
  spms_pkg::slot_idx_t free_mem [spms_pkg::CAPACITY];
  logic [spms_pkg::CAPACITY-1:0] free_vld_q;

  spms_pkg::slot_idx_t stack_top_q   [spms_pkg::STACKS];
  spms_pkg::cnt_t      stack_count_q [spms_pkg::STACKS];
  spms_pkg::serial_t   push_serial_q [spms_pkg::STACKS];
  spms_pkg::cnt_t      pool_count_q, pool_count_d;
  spms_pkg::cnt_t      free_top_q, free_top_d;
  spms_pkg::total_t    cap_q;

  spms_pkg::spms_op_t  op_q;
  logic [1:0]          status_q, status_d;
  spms_pkg::slot_idx_t top_slot_q, top_addr, free_addr;
  spms_pkg::slot_idx_t free_rd_q, free_rd_addr_q, push_slot;
  logic                free_rd_vld_q;
  spms_pkg::serial_t   ser_rd_q, new_serial, rsp_serial;
  spms_pkg::slot_idx_t link_rd_q;

  spms_pkg::spms_rsp_t out_q;
  logic                out_valid_q, out_valid_d;
  spms_pkg::cnt_t      cnt_k;
  logic                issue, fin_fire, do_push, do_pop;

  assign issue       = (state_q == S_ISSUE) && deq_valid_i;
  assign deq_ready_o = (state_q == S_ISSUE);
  assign fin_fire    = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign do_push     = fin_fire && (status_q == spms_pkg::ST_OK) && !op_q.is_pop;
  assign do_pop      = fin_fire && (status_q == spms_pkg::ST_OK) && op_q.is_pop;

  assign cnt_k     = stack_count_q[deq_op_i.stack];
  assign top_addr  = stack_top_q[deq_op_i.stack];
  assign free_addr = spms_pkg::slot_idx_t'(free_top_q - 1'b1);
  assign push_slot = free_rd_vld_q ? free_rd_q : free_rd_addr_q;
  assign new_serial = push_serial_q[op_q.stack] + 16'd1;

  always_comb begin
    if (!deq_op_i.is_pop) begin
      if (!deq_op_i.sel_ok || (32'(pool_count_q) >= 32'(cap_q)) || (free_top_q == '0)) begin
        status_d = spms_pkg::ST_OVF;
      end else begin
        status_d = spms_pkg::ST_OK;
      end
    end else begin
      if (!deq_op_i.sel_ok || (cnt_k == '0) ||
          (32'(free_top_q) >= 32'(spms_pkg::CAPACITY))) begin
        status_d = spms_pkg::ST_UNF;
      end else begin
        status_d = spms_pkg::ST_OK;
      end
    end
  end

  always_comb begin
    pool_count_d = pool_count_q;
    free_top_d   = free_top_q;
    rsp_serial   = '0;
    if (do_push) begin
      pool_count_d = pool_count_q + 1'b1;
      free_top_d   = free_top_q - 1'b1;
      rsp_serial   = new_serial;
    end else if (do_pop) begin
      if (pool_count_q != '0) begin
        pool_count_d = pool_count_q - 1'b1;
      end
      free_top_d = free_top_q + 1'b1;
      rsp_serial = ser_rd_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_ISSUE: begin
        if (issue) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_fire) begin
          state_d     = S_ISSUE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_ISSUE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_ISSUE;
      out_valid_q  <= 1'b0;
      pool_count_q <= '0;
      free_top_q   <= spms_pkg::cnt_t'(spms_pkg::CAPACITY);
      cap_q        <= spms_pkg::CAP_LIMIT_RST;
      free_vld_q   <= '0;
      for (int i = 0; i < spms_pkg::STACKS; i++) begin
        stack_count_q[i] <= '0;
        push_serial_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      pool_count_q <= pool_count_d;
      free_top_q   <= free_top_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (do_push) begin
        stack_count_q[op_q.stack] <= stack_count_q[op_q.stack] + 1'b1;
        push_serial_q[op_q.stack] <= new_serial;
      end else if (do_pop) begin
        stack_count_q[op_q.stack] <= stack_count_q[op_q.stack] - 1'b1;
        free_vld_q[spms_pkg::slot_idx_t'(free_top_q)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      op_q           <= deq_op_i;
      status_q       <= status_d;
      top_slot_q     <= top_addr;
      free_rd_addr_q <= free_addr;
      free_rd_vld_q  <= free_vld_q[free_addr];
    end
    if (do_push) begin
      stack_top_q[op_q.stack] <= push_slot;
    end else if (do_pop) begin
      stack_top_q[op_q.stack] <= link_rd_q;
    end
    if (fin_fire) begin
      out_q.status      <= status_q;
      out_q.item_serial <= rsp_serial;
      out_q.total_count <= spms_pkg::total_t'(pool_count_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      ser_rd_q  <= ser_mem[top_addr];
      link_rd_q <= link_mem[top_addr];
      free_rd_q <= free_mem[free_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ser_mem[push_slot]  <= new_serial;
      link_mem[push_slot] <= (stack_count_q[op_q.stack] != '0) ?
                             stack_top_q[op_q.stack] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      free_mem[spms_pkg::slot_idx_t'(free_top_q)] <= top_slot_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign mon_o.fin        = (state_q == S_FIN);
  assign mon_o.pool_count = pool_count_q;
  assign mon_o.free_top   = free_top_q;

endmodule

/* rtl/shared_pool_multi_stack_unit.sv */
// Top level of the shared-pool multi-stack unit: front decoder and queue plus back end.
// Depends on spms_pkg, spms_front and spms_back.
//
// Eight LIFO stacks share a pool of 64 slots, and a push overflows once the total held
// reaches the capacity limit written on the configuration port (reset value 64). Each
// operation passes an issue state, which reads the slot, link and free-list memories,
// and a finishing state, which writes them and loads the result register; the back end
// takes no new item until the last has finished, and the finishing state waits while
// the result register is still full. A two-entry queue lets requests be accepted while
// the back end or the result register is busy. The free list is ready right after reset,
// with no clearing pass.
module shared_pool_multi_stack_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [6:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spms_pkg::spms_req_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output spms_pkg::spms_rsp_t out_data_o
);

  logic                deq_valid, deq_ready;
  spms_pkg::spms_op_t  deq_op;
  spms_pkg::spms_mon_t mon;

  assign cfg_ready_o = 1'b1;

  spms_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .deq_valid_o (deq_valid),
    .deq_ready_i (deq_ready),
    .deq_op_o    (deq_op)
  );

  spms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .deq_valid_i (deq_valid),
    .deq_ready_o (deq_ready),
    .deq_op_i    (deq_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mon_o       (mon)
  );

  a_pool_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(mon.pool_count) + 32'(mon.free_top) == 32'(spms_pkg::CAPACITY))
    else $error("Pool count and free-list depth do not add up to the pool size.");

  a_fail_serial_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != spms_pkg::ST_OK)) |-> (out_data_o.item_serial == '0))
    else $error("A failed operation returned a nonzero serial.");

  a_result_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(mon.fin))
    else $error("A result appeared without a finishing back-end cycle.");

  a_total_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (out_data_o.total_count == spms_pkg::total_t'(mon.pool_count)))
    else $error("Reported total differs from the pool count.");

endmodule

/* tb/shared_pool_multi_stack_unit_test.sv */
// Self-checking testbench for shared_pool_multi_stack_unit: directed, capacity, backpressure
// and random push/pop traffic checked against an in-bench stack-pool predictor.
// Depends on spms_pkg and the shared_pool_multi_stack_unit RTL.
module shared_pool_multi_stack_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  localparam int unsigned CYCLE_LIMIT = 50_000;
  localparam int          MAX_REPORTS = 40;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [6:0]          cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  spms_pkg::spms_req_t in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  spms_pkg::spms_rsp_t out_data_o;

  shared_pool_multi_stack_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Predicted pool state.
  spms_pkg::serial_t slot_tag   [spms_pkg::CAPACITY];
  int                slot_below [spms_pkg::CAPACITY];
  int                free_list  [spms_pkg::CAPACITY];
  int                free_cnt;
  int                top_of     [spms_pkg::STACKS];
  int                depth_of   [spms_pkg::STACKS];
  spms_pkg::serial_t tag_of     [spms_pkg::STACKS];
  int                held_total;
  int                cap_limit;

  spms_pkg::spms_rsp_t expected_rsp[$];

  int          errors;
  int          reports;
  int          items_sent;
  int          limit_writes;
  int          ok_count;
  int          ovf_count;
  int          unf_count;
  int          peak_total;
  int unsigned cycle_count;

  bit        tx_bursty;
  int        burst_left;
  rx_mode_e  rx_mode;
  int        rx_hold_req;
  int        rx_hold_left;
  logic [6:0] rx_pattern = 7'b1101001;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles with %0d results pending", cycle_count,
                 expected_rsp.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rx_hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req > 0) begin
        rx_hold_left = rx_hold_req;
        rx_hold_req  = 0;
      end
      if (rx_hold_left > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_left--;
      end else begin
        case (rx_mode)
          RX_ALWAYS: begin
            out_ready_i <= 1'b1;
          end
          RX_RANDOM: begin
            out_ready_i <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_ready_i <= rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[6:1]};
          end
        endcase
      end
    end
  end

  task automatic model_reset();
    for (int i = 0; i < spms_pkg::CAPACITY; i++) begin
      slot_tag[i]   = '0;
      slot_below[i] = 0;
      free_list[i]  = i;
    end
    for (int k = 0; k < spms_pkg::STACKS; k++) begin
      top_of[k]   = 0;
      depth_of[k] = 0;
      tag_of[k]   = '0;
    end
    free_cnt   = spms_pkg::CAPACITY;
    held_total = 0;
    cap_limit  = int'(spms_pkg::CAP_LIMIT_RST);
  endtask

  function automatic spms_pkg::spms_rsp_t apply_op(spms_pkg::spms_req_t op);
    spms_pkg::spms_rsp_t r;
    int                  k;
    int                  s;
    r        = '0;
    r.status = (op.req_type == spms_pkg::REQ_POP) ? spms_pkg::ST_UNF : spms_pkg::ST_OVF;
    if (op.stack_select >= 1 && op.stack_select <= spms_pkg::STACKS) begin
      k = int'(op.stack_select) - 1;
      if (op.req_type == spms_pkg::REQ_PUSH) begin
        if (held_total < cap_limit && free_cnt > 0) begin
          free_cnt--;
          s             = free_list[free_cnt];
          tag_of[k]     = tag_of[k] + 16'd1;
          slot_tag[s]   = tag_of[k];
          slot_below[s] = (depth_of[k] != 0) ? top_of[k] : 0;
          top_of[k]     = s;
          depth_of[k]++;
          held_total++;
          r.status      = spms_pkg::ST_OK;
          r.item_serial = tag_of[k];
        end
      end else if (depth_of[k] != 0 && free_cnt < spms_pkg::CAPACITY) begin
        s                   = top_of[k];
        r.item_serial       = slot_tag[s];
        top_of[k]           = slot_below[s];
        free_list[free_cnt] = s;
        free_cnt++;
        depth_of[k]--;
        if (held_total > 0) held_total--;
        r.status = spms_pkg::ST_OK;
      end
    end
    r.total_count = spms_pkg::total_t'(held_total);
    return r;
  endfunction

  function automatic spms_pkg::spms_req_t mk_op(logic kind, int stack);
    spms_pkg::spms_req_t op;
    op.req_type     = kind;
    op.stack_select = 4'(stack);
    return op;
  endfunction

  function automatic spms_pkg::spms_req_t rand_op(int push_pct);
    spms_pkg::spms_req_t op;
    op.req_type = ($urandom_range(0, 99) < push_pct) ? spms_pkg::REQ_PUSH : spms_pkg::REQ_POP;
    if ($urandom_range(0, 9) == 0) begin
      op.stack_select = ($urandom_range(0, 1) == 0) ? 4'd0 :
                        4'($urandom_range(spms_pkg::STACKS + 1, 15));
    end else if ($urandom_range(0, 1) == 0) begin
      op.stack_select = 4'($urandom_range(1, 2));
    end else begin
      op.stack_select = 4'($urandom_range(1, spms_pkg::STACKS));
    end
    return op;
  endfunction

  task automatic flag_mismatch(string what, int want, int got);
    errors++;
    if (reports < MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end else if (reports == MAX_REPORTS) begin
      $display("%0t: further mismatches are counted but not reported", $time);
    end
    reports++;
  endtask

  initial begin
    spms_pkg::spms_rsp_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_rsp.size() == 0) begin
          flag_mismatch("unexpected item, status", -1, int'(out_data_o.status));
        end else begin
          want = expected_rsp.pop_front();
          if (out_data_o.status !== want.status)
            flag_mismatch("status", int'(want.status), int'(out_data_o.status));
          if (out_data_o.item_serial !== want.item_serial)
            flag_mismatch("item_serial", int'(want.item_serial), int'(out_data_o.item_serial));
          if (out_data_o.total_count !== want.total_count)
            flag_mismatch("total_count", int'(want.total_count), int'(out_data_o.total_count));
          case (want.status)
            spms_pkg::ST_OK:  ok_count++;
            spms_pkg::ST_OVF: ovf_count++;
            default:          unf_count++;
          endcase
          if (int'(want.total_count) > peak_total) peak_total = int'(want.total_count);
        end
      end
    end
  end

  task automatic send_op(spms_pkg::spms_req_t op);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= op;
    do @(posedge clk_i); while (!in_ready_o);
    expected_rsp.push_back(apply_op(op));
    items_sent++;
    gap = 0;
    if (tx_bursty) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 5);
        burst_left = $urandom_range(1, 10);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [6:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cap_limit = int'(value);
    limit_writes++;
  endtask

  task automatic test_directed();
    tx_bursty = 1'b1;
    rx_mode   = RX_RANDOM;
    send_op(mk_op(spms_pkg::REQ_POP, 1));
    send_op(mk_op(spms_pkg::REQ_PUSH, 1));
    send_op(mk_op(spms_pkg::REQ_PUSH, spms_pkg::STACKS));
    send_op(mk_op(spms_pkg::REQ_POP, spms_pkg::STACKS));
    send_op(mk_op(spms_pkg::REQ_POP, 1));
    send_op(mk_op(spms_pkg::REQ_PUSH, 0));
    send_op(mk_op(spms_pkg::REQ_POP, 0));
    send_op(mk_op(spms_pkg::REQ_PUSH, spms_pkg::STACKS + 1));
    send_op(mk_op(spms_pkg::REQ_POP, 15));
    send_op(mk_op(spms_pkg::REQ_PUSH, 15));
    repeat (3) send_op(mk_op(spms_pkg::REQ_PUSH, 1));
    repeat (4) send_op(mk_op(spms_pkg::REQ_POP, 1));
    send_op(mk_op(spms_pkg::REQ_PUSH, 4));
    send_op(mk_op(spms_pkg::REQ_POP, 4));
    drain();
  endtask

  task automatic test_capacity_limit();
    tx_bursty = 1'b1;
    rx_mode   = RX_PATTERN;
    write_limit(7'd0);
    send_op(mk_op(spms_pkg::REQ_PUSH, 3));
    send_op(mk_op(spms_pkg::REQ_POP, 3));
    drain();
    write_limit(7'd3);
    for (int s = 1; s <= 4; s++) send_op(mk_op(spms_pkg::REQ_PUSH, s));
    for (int s = 1; s <= 4; s++) send_op(mk_op(spms_pkg::REQ_POP, s));
    drain();
    write_limit(7'd127);
    for (int i = 0; i <= spms_pkg::CAPACITY; i++) begin
      send_op(mk_op(spms_pkg::REQ_PUSH, (i % spms_pkg::STACKS) + 1));
    end
    for (int s = 1; s <= spms_pkg::STACKS; s++) begin
      repeat (spms_pkg::CAPACITY / spms_pkg::STACKS + 1) send_op(mk_op(spms_pkg::REQ_POP, s));
    end
    drain();
    write_limit(7'd64);
  endtask

  task automatic test_input_backpressure();
    tx_bursty   = 1'b0;
    rx_mode     = RX_ALWAYS;
    rx_hold_req = 80;
    for (int i = 0; i < 20; i++) send_op(rand_op(60));
    drain();
  endtask

  task automatic run_phase(int count, logic [6:0] limit, rx_mode_e mode, bit bursty);
    int push_pct;
    write_limit(limit);
    rx_mode   = mode;
    tx_bursty = bursty;
    for (int i = 0; i < count; i++) begin
      push_pct = ((i / 35) % 2 == 0) ? 75 : 30;
      send_op(rand_op(push_pct));
    end
    drain();
  endtask

  task automatic test_random_traffic();
    run_phase(90, 7'd127, RX_RANDOM, 1'b1);
    run_phase(90, 7'($urandom_range(1, 16)), RX_PATTERN, 1'b1);
    run_phase(90, 7'd64, RX_ALWAYS, 1'b0);
    run_phase(90, 7'($urandom_range(20, 63)), RX_RANDOM, 1'b1);
  endtask

  initial begin
    errors       = 0;
    reports      = 0;
    items_sent   = 0;
    limit_writes = 0;
    ok_count     = 0;
    ovf_count    = 0;
    unf_count    = 0;
    peak_total   = 0;
    burst_left   = 0;
    rx_hold_req  = 0;
    tx_bursty    = 1'b0;
    rx_mode      = RX_ALWAYS;
    model_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_capacity_limit();
    test_input_backpressure();
    test_random_traffic();
    $display("Covered %0d operations: %0d succeeded, %0d overflowed, %0d underflowed.",
             items_sent, ok_count, ovf_count, unf_count);
    $display("Pool peaked at %0d held, %0d limit writes, %0d errors.",
             peak_total, limit_writes, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/spms_pkg.sv
rtl/spms_front.sv
rtl/spms_back.sv
rtl/shared_pool_multi_stack_unit.sv
tb/shared_pool_multi_stack_unit_test.sv
